FILE: hw/rtl/sfp_pkg.sv
// Shared constants, types and helpers for the scale frame parser.
// No dependencies; compiled first.
package sfp_pkg;

    // frame layout (positions counted from 1)
    localparam int FRAME_LEN       = 17;
    localparam int NUMBER_CHARS    = 7;
    localparam int STABLE_READINGS = 3;
    localparam int COMMA_POS_A     = 3;
    localparam int COMMA_POS_B     = 6;
    localparam int SIGN_POS        = 7;
    localparam int NUM_FIRST       = 8;
    localparam int NUM_LAST        = NUM_FIRST + NUMBER_CHARS - 1;

    localparam int LEN_W      = $clog2(FRAME_LEN + 1);
    localparam int BYTE_W     = 8;
    localparam int MANT_W     = 24;
    localparam int FRAC_W     = 3;
    localparam int POW_W      = 24;
    localparam int SCALED_W   = MANT_W + POW_W;
    localparam int WEIGHT_W   = MANT_W + 1;
    localparam int CNT_W      = 2;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 3'd7;

    // characters
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h67;

    typedef struct packed {
        logic              neg;
        logic [MANT_W-1:0] mant;
        logic [FRAC_W-1:0] frac;
    } reading_t;

    // 10^(7-frac): scales a mantissa to seven fraction digits
    function automatic logic [POW_W-1:0] frac_scale(input logic [FRAC_W-1:0] frac);
        logic [POW_W-1:0] p;
        begin
            case (frac)
                3'd0:    p = 24'd10000000;
                3'd1:    p = 24'd1000000;
                3'd2:    p = 24'd100000;
                3'd3:    p = 24'd10000;
                3'd4:    p = 24'd1000;
                3'd5:    p = 24'd100;
                3'd6:    p = 24'd10;
                default: p = 24'd1;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: hw/rtl/sfp_byte_if.sv
// Byte channel into the scale frame parser: valid/ready plus one received byte.
// Depends on sfp_pkg.
interface sfp_byte_if import sfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/sfp_result_if.sv
// Result channel of the scale frame parser: valid/ready plus the published reading.
// Depends on sfp_pkg.
interface sfp_result_if import sfp_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight_mantissa;
    logic [FRAC_W-1:0]          frac_digits;
    logic                       stable;

    modport source (output valid, output weight_mantissa, output frac_digits,
                    output stable, input ready);
    modport sink   (input valid, input weight_mantissa, input frac_digits,
                    input stable, output ready);
endinterface

FILE: hw/rtl/scale_frame_parser.sv
// Scale frame parser top level: line checker, number parser, scaling and group compare.
// Depends on sfp_pkg, sfp_byte_if and sfp_result_if.

// Takes one byte per clock from the indicator link. Each line is checked and
// parsed as it arrives; a CR or LF ending a full-length line yields a reading,
// which passes a scaling stage (mantissa times a power of ten, one 24x24
// multiply) and then a group compare stage. Every third reading produces one
// result, registered on the output after its reading has passed stages A and
// B while the output register is free; a held result freezes the
// scaling and compare stages until the sink takes it. rx.ready stays high
// except when the result register is held by the sink and two further
// readings are already in flight; while it is low no byte at all is taken.
module scale_frame_parser import sfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfp_byte_if.sink      rx,
    sfp_result_if.source  result
);

    // line parser state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              neg_reg, neg_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic              point_reg, point_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              started_reg, started_next;
    logic              ended_reg, ended_next;

    // pipeline
    logic              a_vld_reg;
    reading_t          a_rd_reg;
    logic              b_vld_reg;
    reading_t          b_rd_reg;
    logic [SCALED_W-1:0] b_scaled_reg;

    // group compare state
    logic [CNT_W-1:0]    cnt_reg;
    logic                early_neg_reg [2];
    logic [SCALED_W-1:0] early_mag_reg [2];
    reading_t            pub_reg;

    logic                       out_vld_reg;
    logic signed [WEIGHT_W-1:0] out_mant_reg;
    logic [FRAC_W-1:0]          out_frac_reg;
    logic                       out_stable_reg;

    logic              rx_fire;
    logic              rd_fire;
    logic [BYTE_W-1:0] c;
    logic [LEN_W-1:0]  pos;
    logic              is_term;
    logic              bad;
    logic              o_stall;
    logic              b_adv;
    logic              a_adv;
    logic              c_take;
    logic              same0;
    logic              same1;
    logic              same;
    logic              emit;
    reading_t          sel;
    logic [WEIGHT_W-1:0] mag25;
    logic [SCALED_W-1:0] prod;

    assign o_stall  = out_vld_reg && !result.ready;
    assign b_adv    = !o_stall;
    assign a_adv    = !b_vld_reg || b_adv;
    assign rx.ready = !a_vld_reg || a_adv;
    assign rx_fire  = rx.valid && rx.ready;

    assign c       = rx.rx_byte;
    assign pos     = len_reg + 1'b1;
    assign is_term = (c == CH_LF) || (c == CH_CR);
    assign bad     = (((pos == LEN_W'(COMMA_POS_A)) || (pos == LEN_W'(COMMA_POS_B)))
                        && (c != CH_COMMA))
                  || ((pos == LEN_W'(FRAME_LEN - 1)) && (c != CH_K))
                  || ((pos == LEN_W'(FRAME_LEN)) && (c != CH_G));

    always_comb
    begin
        len_next     = len_reg;
        neg_next     = neg_reg;
        mant_next    = mant_reg;
        point_next   = point_reg;
        frac_next    = frac_reg;
        started_next = started_reg;
        ended_next   = ended_reg;
        rd_fire      = 1'b0;
        if (rx_fire)
        begin
            if (is_term || ((len_reg < LEN_W'(FRAME_LEN)) && bad))
            begin
                // terminator completes a full line; a wrong character restarts it
                rd_fire      = is_term && (len_reg >= LEN_W'(FRAME_LEN));
                len_next     = '0;
                neg_next     = 1'b0;
                mant_next    = '0;
                point_next   = 1'b0;
                frac_next    = '0;
                started_next = 1'b0;
                ended_next   = 1'b0;
            end
            else if (len_reg < LEN_W'(FRAME_LEN))
            begin
                if (pos == LEN_W'(SIGN_POS))
                begin
                    neg_next = (c == CH_MINUS);
                end
                if ((pos >= LEN_W'(NUM_FIRST)) && (pos <= LEN_W'(NUM_LAST)) && !ended_reg)
                begin
                    if ((c == CH_SPACE) && !started_reg)
                    begin
                        neg_next = neg_next; // leading blank
                    end
                    else if ((c >= CH_ZERO) && (c <= CH_NINE))
                    begin
                        // times ten plus digit, kept to 24 bits
                        mant_next = MANT_W'({mant_reg, 3'b000}) + MANT_W'({mant_reg, 1'b0})
                                  + MANT_W'(c[3:0]);
                        started_next = 1'b1;
                        if (point_reg && (frac_reg < FRAC_MAX))
                        begin
                            frac_next = frac_reg + 1'b1;
                        end
                    end
                    else if ((c == CH_POINT) && !point_reg)
                    begin
                        point_next   = 1'b1;
                        started_next = 1'b1;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end
                len_next = pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            neg_reg     <= 1'b0;
            mant_reg    <= '0;
            point_reg   <= 1'b0;
            frac_reg    <= '0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            neg_reg     <= neg_next;
            mant_reg    <= mant_next;
            point_reg   <= point_next;
            frac_reg    <= frac_next;
            started_reg <= started_next;
            ended_reg   <= ended_next;
        end
    end

    // stage A: completed reading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (rd_fire)
        begin
            a_vld_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            a_rd_reg.neg  <= neg_reg;
            a_rd_reg.mant <= mant_reg;
            a_rd_reg.frac <= frac_reg;
        end
    end

    // stage B: value scaled to seven fraction digits
    assign prod = a_rd_reg.mant * frac_scale(a_rd_reg.frac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_rd_reg     <= a_rd_reg;
            b_scaled_reg <= prod;
        end
    end

    // stage C: group compare; minus zero equals zero
    assign c_take = b_vld_reg && b_adv;
    assign same0  = (b_scaled_reg == early_mag_reg[0])
                 && ((b_rd_reg.neg == early_neg_reg[0]) || (b_scaled_reg == '0));
    assign same1  = (b_scaled_reg == early_mag_reg[1])
                 && ((b_rd_reg.neg == early_neg_reg[1]) || (b_scaled_reg == '0));
    assign same   = same0 && ((STABLE_READINGS < 3) || same1);
    assign emit   = c_take && (cnt_reg >= CNT_W'(STABLE_READINGS - 1));
    assign sel    = same ? b_rd_reg : pub_reg;
    assign mag25  = {1'b0, sel.mant};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pub_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_take)
            begin
                if (emit)
                begin
                    cnt_reg <= '0;
                    if (same)
                    begin
                        pub_reg <= b_rd_reg;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_take && !emit)
        begin
            early_neg_reg[cnt_reg[0]] <= b_rd_reg.neg;
            early_mag_reg[cnt_reg[0]] <= b_scaled_reg;
        end
        if (emit)
        begin
            out_mant_reg   <= sel.neg ? signed'(~mag25 + 1'b1) : signed'(mag25);
            out_frac_reg   <= sel.frac;
            out_stable_reg <= same;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.weight_mantissa = out_mant_reg;
    assign result.frac_digits     = out_frac_reg;
    assign result.stable          = out_stable_reg;

endmodule

FILE: hw/rtl/sfp_checker.sv
// Port-level checks for scale_frame_parser, attached by bind.
// Depends on sfp_pkg and the top level's interface ports.
module sfp_checker import sfp_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rx_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic signed [WEIGHT_W-1:0] weight_mantissa,
    input logic [FRAC_W-1:0]          frac_digits,
    input logic                       stable
);

    // input back-pressure only ever comes from a held result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> res_valid)
        else $error("rx not ready without a pending result");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(weight_mantissa)
            && $stable(frac_digits) && $stable(stable))
        else $error("stalled result changed");

    // magnitude is a 24-bit mantissa, so the most negative code cannot occur
    a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> weight_mantissa != {1'b1, {(WEIGHT_W-1){1'b0}}})
        else $error("weight mantissa out of range");

    a_rx_idle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_ready))
        else $error("result appeared while input was blocked");

endmodule

bind scale_frame_parser sfp_checker u_sfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_ready        (rx.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .weight_mantissa (result.weight_mantissa),
    .frac_digits     (result.frac_digits),
    .stable          (result.stable)
);
